>>> rtl/nvr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nvr_pkg
// Shared types and constants of the ratio-of-uniforms normal variate block.
// ----------------------------------------------------------------------------
package nvr_pkg;

  typedef struct packed {
    logic [31:0] draw_first;
    logic [31:0] draw_second;
  } nvr_req_t;

  typedef struct packed {
    logic signed [31:0] variate;
    logic               clipped;
  } nvr_rsp_t;

  // Sideband carried alongside the divider stages.
  typedef struct packed {
    logic valid;
    logic neg;
  } nvr_tag_t;

  // Significant bits of each uniform draw.
  localparam int unsigned UniformBits = 32;

  localparam int unsigned QuoBits     = 35;
  localparam int unsigned DivStages   = QuoBits;
  localparam int unsigned LogFracBits = 28;
  localparam int unsigned LogStages   = LogFracBits + 1;
  localparam int unsigned LogDelay    = DivStages - LogStages;

  localparam logic [30:0] CQ30   = 31'd1842033917;
  localparam logic [29:0] Ln2Q30 = 30'd744261118;
  localparam logic [34:0] ZqLimit = 35'd10 << 30;

  localparam logic [1:0] CFG_MEAN = 2'd0;
  localparam logic [1:0] CFG_STD  = 2'd1;

endpackage
`default_nettype wire

>>> rtl/nvr_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nvr_divider
// Restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module nvr_divider import nvr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire logic [61:0]       num_i,
  input  wire logic [32:0]       den_i,
  input  wire nvr_tag_t          tag_i,
  output logic [QuoBits-1:0]     quo_o,
  output logic                   big_o,
  output nvr_tag_t               tag_o
);

  logic [61:0]        rem_q [DivStages];
  logic [32:0]        den_q [DivStages];
  logic [QuoBits-1:0] quo_q [DivStages];
  logic               big_q [DivStages];
  nvr_tag_t           tag_q [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic [61:0]        rem_in;
    logic [32:0]        den_in;
    logic [QuoBits-1:0] quo_in;
    logic               big_in;
    nvr_tag_t           tag_in;
    logic [67:0]        shifted;
    logic               ge;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      // quotient beyond the kept bits: reject outright
      assign big_in = {6'd0, num_i} >= {den_i, 35'd0};
      assign tag_in = tag_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
      assign big_in = big_q[s-1];
      assign tag_in = tag_q[s-1];
    end

    assign shifted = {35'd0, den_in} << (QuoBits - 1 - s);
    assign ge      = {6'd0, rem_in} >= shifted;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[s] <= '0;
      end else if (adv_i) begin
        tag_q[s] <= tag_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s] <= ge ? (rem_in - shifted[61:0]) : rem_in;
        den_q[s] <= den_in;
        quo_q[s] <= {quo_in[QuoBits-2:0], ge};
        big_q[s] <= big_in;
      end
    end
  end

  assign quo_o = quo_q[DivStages-1];
  assign big_o = big_q[DivStages-1];
  assign tag_o = tag_q[DivStages-1];

endmodule
`default_nettype wire

>>> rtl/nvr_log2.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nvr_log2
// Pipelined log2 by normalisation and repeated squaring, one fraction bit
// per stage.
// ----------------------------------------------------------------------------
module nvr_log2 import nvr_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    adv_i,
  input  wire logic [32:0]             den_i,
  output logic [LogFracBits+5:0]       log_o
);

  logic [31:0]            x_q    [LogStages];
  logic [5:0]             e_q    [LogStages];
  logic [LogFracBits-1:0] frac_q [LogStages];

  // Normalise: find the leading one and align the mantissa to Q1.31.
  logic [5:0]  lead;
  logic [63:0] norm;
  always_comb begin
    lead = '0;
    for (int i = 0; i < 33; i++) begin
      if (den_i[i]) lead = 6'(i);
    end
    norm = {31'd0, den_i} << (6'd31 - lead);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q[0]    <= (lead == 6'd32) ? den_i[32:1] : norm[31:0];
      e_q[0]    <= lead;
      frac_q[0] <= '0;
    end
  end

  for (genvar j = 1; j < LogStages; j++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;
    logic [LogFracBits-1:0] frac_d;
    assign sq = 64'(x_q[j-1]) * 64'(x_q[j-1]);
    assign t  = sq[63:31];
    always_comb begin
      frac_d = frac_q[j-1];
      frac_d[LogFracBits-j] = t[32];
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        x_q[j]    <= t[32] ? t[32:1] : t[31:0];
        e_q[j]    <= e_q[j-1];
        frac_q[j] <= frac_d;
      end
    end
  end

  assign log_o = {e_q[LogStages-1], frac_q[LogStages-1]};

endmodule
`default_nettype wire

>>> rtl/normal_variate_ratio_of_uniforms.sv
`default_nettype none
// ----------------------------------------------------------------------------
// normal_variate_ratio_of_uniforms
// Normal variate generator, ratio-of-uniforms acceptance test in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Feed pairs of uniform draws on the request channel (in_valid_i/in_ready_o).
//   Each pair forms z = C*(r1-1/2)/(1-r2); a pair passing z^2/4 <= -ln(1-r2)
//   yields one result mean + z*stddev (Q16.16, saturated, clipped flag) on
//   the result channel (out_valid_o/out_ready_i). A rejected pair yields
//   nothing, so results appear at a rate set by the acceptance ratio.
//   Throughput: one request per cycle while the receiver does not stall.
//   The path is 40 register stages (input stage, 35-stage restoring divider
//   with the 29-stage squaring log2 alongside it, three finishing stages,
//   output register).
//   The divider, one quotient bit per stage, sets the depth.
//   A stalled receiver freezes the whole pipeline and the output register;
//   in_ready_o drops in the same cycle, so nothing is lost or repeated.
//   Reset clears every valid bit and both configuration registers (mean 0,
//   stddev 0). Write mean_value and std_deviation through cfg_we_i while the
//   block is idle; writes take effect at once.
// ----------------------------------------------------------------------------
module normal_variate_ratio_of_uniforms import nvr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire nvr_req_t    in_req_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output nvr_rsp_t         out_rsp_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int unsigned ShL = (UniformBits < 32) ? (32 - UniformBits) : 0;
  localparam int unsigned ShR = (UniformBits > 32) ? (UniformBits - 32) : 0;

  // Configuration registers.
  logic signed [31:0] mean_q;
  logic        [30:0] std_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= '0;
      std_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MEAN: mean_q <= cfg_data_i;
        CFG_STD:  std_q  <= cfg_data_i[30:0];
        default:  ;
      endcase
    end
  end

  // Advance everything unless a finished result is held back.
  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // Input stage: align draws, form 1 - r2, |r1 - 1/2| and the dividend.
  logic [31:0] r1, r2;
  logic [32:0] den;
  logic        neg;
  logic [31:0] r1_off;
  assign r1     = (in_req_i.draw_first  << ShL) >> ShR;
  assign r2     = (in_req_i.draw_second << ShL) >> ShR;
  assign den    = 33'h1_0000_0000 - {1'b0, r2};
  assign neg    = !r1[31];
  assign r1_off = neg ? (32'h8000_0000 - r1) : (r1 - 32'h8000_0000);

  logic [61:0] num_q;
  logic [32:0] den_q;
  nvr_tag_t    tag0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag0_q <= '0;
    end else if (adv) begin
      tag0_q <= '{valid: in_valid_i, neg: neg};
    end
  end

  logic [62:0] prod0;
  assign prod0 = 63'(CQ30) * 63'(r1_off);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q <= prod0[61:0];
      den_q <= den;
    end
  end

  // Divider and log2 side by side.
  logic [QuoBits-1:0]     zq;
  logic                   big;
  nvr_tag_t               tag_a;
  logic [LogFracBits+5:0] log_raw;

  nvr_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .num_i  (num_q),
    .den_i  (den_q),
    .tag_i  (tag0_q),
    .quo_o  (zq),
    .big_o  (big),
    .tag_o  (tag_a)
  );

  nvr_log2 u_log (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .den_i  (den_q),
    .log_o  (log_raw)
  );

  // Hold log2 back until the quotient catches up.
  logic [LogFracBits+5:0] log_dly_q [LogDelay];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      log_dly_q[0] <= log_raw;
      for (int i = 1; i < LogDelay; i++) begin
        log_dly_q[i] <= log_dly_q[i-1];
      end
    end
  end

  // Stage B: z^2, -ln(1-r2) and the range check on the quotient.
  logic [31:0] zh;
  logic [63:0] zz_full;
  logic [33:0] nl2;
  logic [63:0] nln_full;
  logic        rej;
  assign zh       = zq[33:2];
  assign zz_full  = 64'(zh) * 64'(zh);
  assign nl2      = (34'd32 << LogFracBits) - log_dly_q[LogDelay-1];
  assign nln_full = 64'(nl2) * 64'(Ln2Q30);
  assign rej      = big || (zq >= ZqLimit);

  logic        vb_q, negb_q;
  logic [35:0] zz_q;
  logic [33:0] nln_q;
  logic [33:0] zqb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (adv) begin
      vb_q <= tag_a.valid && !rej;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      negb_q <= tag_a.neg;
      zz_q   <= zz_full[63:28];
      nln_q  <= nln_full[63:30];
      zqb_q  <= zq[33:0];
    end
  end

  // Stage C: acceptance test and the split |z| * stddev products.
  logic        vc_q, negc_q;
  logic [48:0] hi_q;
  logic [49:0] lo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (adv) begin
      vc_q <= vb_q && !(zz_q > {nln_q, 2'b00});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      negc_q <= negb_q;
      hi_q   <= 49'(zqb_q) * 49'(std_q[30:16]);
      lo_q   <= 50'(zqb_q) * 50'(std_q[15:0]);
    end
  end

  // Stage D: round the product back to Q16.16, ties away from zero.
  logic [50:0] low_sum;
  logic [35:0] mag;
  assign low_sum = {21'd0, hi_q[13:0], 16'd0} + {1'b0, lo_q} + (51'd1 << 29);
  assign mag     = 36'(hi_q[48:14]) + 36'(low_sum[50:30]);

  logic        vd_q, negd_q;
  logic [35:0] mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (adv) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      negd_q <= negc_q;
      mag_q  <= mag;
    end
  end

  // Output: add the mean, saturate, register.
  logic signed [37:0] sum;
  nvr_rsp_t           rsp_d;
  always_comb begin
    sum = 38'(mean_q) + (negd_q ? -$signed({2'b00, mag_q}) : $signed({2'b00, mag_q}));
    rsp_d.clipped = 1'b0;
    rsp_d.variate = sum[31:0];
    if (sum > 38'sd2147483647) begin
      rsp_d.variate = 32'h7FFF_FFFF;
      rsp_d.clipped = 1'b1;
    end else if (sum < -38'sd2147483648) begin
      rsp_d.variate = 32'h8000_0000;
      rsp_d.clipped = 1'b1;
    end
  end

  nvr_rsp_t rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule
`default_nettype wire
